FILE: rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/ccgd_pkg.sv
package ccgd_pkg;

   localparam int DIM_BITS       = 12;
   localparam int OUT_WIDTH      = 96;
   localparam int OUT_HEIGHT     = 96;
   localparam int OUT_COL_BITS   = $clog2(OUT_WIDTH + 1);
   localparam int OUT_ROW_BITS   = $clog2(OUT_HEIGHT + 1);
   localparam int COL_REM_BITS   = $clog2(OUT_WIDTH);
   localparam int ROW_REM_BITS   = $clog2(OUT_HEIGHT);
   localparam int RECIP_X        = (2 ** DIM_BITS) / OUT_WIDTH;
   localparam int RECIP_Y        = (2 ** DIM_BITS) / OUT_HEIGHT;
   localparam int SETTLE_CYCLES  = 5;
   localparam int SETTLE_BITS    = $clog2(SETTLE_CYCLES + 1);
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int PIXEL_BITS     = 16;
   localparam int GRAY_BITS      = 8;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [17:0] W_RED   = 18'd161185;
   localparam logic [17:0] W_GREEN = 18'd155712;
   localparam logic [15:0] W_BLUE  = 16'd61456;

   localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET  = DIM_BITS'(320);
   localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = DIM_BITS'(240);

   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [DIM_BITS-1:0] frame_width;
      logic [DIM_BITS-1:0] frame_height;
   } cfg_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  image_last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

FILE: rtl/ccgd_front.sv
module ccgd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  ccgd_pkg::cfg_type              cfg,
   input  logic                           cfg_write,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ccgd_pkg::PIXEL_BITS-1:0] req_pixel,
   input  logic                           req_frame_start,
   input  ccgd_pkg::queue_status_type     queue_status,
   output logic                           push_valid,
   output ccgd_pkg::entry_type            push_entry
);
   import ccgd_pkg::*;

   logic [SETTLE_BITS-1:0] settle_ff, settle_in;
   logic                   busy;

   logic [DIM_BITS-1:0]     side_ff, side_in;
   logic [DIM_BITS-1:0]     start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [2*DIM_BITS-1:0]   prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic [DIM_BITS-1:0]     q_est_x_ff, q_est_x_in, q_est_y_ff, q_est_y_in;
   logic [DIM_BITS-1:0]     r_est_x_ff, r_est_x_in, r_est_y_ff, r_est_y_in;
   logic [DIM_BITS-1:0]     step_q_x_ff, step_q_x_in, step_q_y_ff, step_q_y_in;
   logic [COL_REM_BITS-1:0] step_r_x_ff, step_r_x_in;
   logic [ROW_REM_BITS-1:0] step_r_y_ff, step_r_y_in;

   logic [DIM_BITS-1:0]     src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [OUT_COL_BITS-1:0] out_col_ff, out_col_in;
   logic [OUT_ROW_BITS-1:0] out_row_ff, out_row_in;
   logic [DIM_BITS-1:0]     col_target_ff, col_target_in, row_target_ff, row_target_in;
   logic [COL_REM_BITS-1:0] col_rem_ff, col_rem_in;
   logic [ROW_REM_BITS-1:0] row_rem_ff, row_rem_in;

   logic                    accept;
   logic                    row_hit;
   logic                    sel;
   logic                    last;
   logic                    row_end;
   logic [DIM_BITS-1:0]     cur_src_col, cur_src_row, cur_col_target, cur_row_target;
   logic [OUT_COL_BITS-1:0] cur_out_col;
   logic [OUT_ROW_BITS-1:0] cur_out_row;
   logic [COL_REM_BITS-1:0] cur_col_rem;
   logic [ROW_REM_BITS-1:0] cur_row_rem;
   logic [COL_REM_BITS:0]   col_sum;
   logic [ROW_REM_BITS:0]   row_sum;
   logic                    col_carry;
   logic                    row_carry;

   // crop origin and step, registered, derived from the frame size
   always_comb begin
      side_in    = (cfg.frame_width < cfg.frame_height) ? cfg.frame_width : cfg.frame_height;
      start_x_in = (cfg.frame_width - side_in) >> 1;
      start_y_in = (cfg.frame_height - side_in) >> 1;
      prod_x_in  = (2*DIM_BITS)'(side_ff) * (2*DIM_BITS)'(RECIP_X);
      prod_y_in  = (2*DIM_BITS)'(side_ff) * (2*DIM_BITS)'(RECIP_Y);
      q_est_x_in = prod_x_ff[2*DIM_BITS-1:DIM_BITS];
      q_est_y_in = prod_y_ff[2*DIM_BITS-1:DIM_BITS];
      r_est_x_in = side_ff - DIM_BITS'(q_est_x_in * DIM_BITS'(OUT_WIDTH));
      r_est_y_in = side_ff - DIM_BITS'(q_est_y_in * DIM_BITS'(OUT_HEIGHT));
      if (r_est_x_ff >= DIM_BITS'(OUT_WIDTH)) begin
         step_q_x_in = q_est_x_ff + DIM_BITS'(1);
         step_r_x_in = COL_REM_BITS'(r_est_x_ff - DIM_BITS'(OUT_WIDTH));
      end else begin
         step_q_x_in = q_est_x_ff;
         step_r_x_in = COL_REM_BITS'(r_est_x_ff);
      end
      if (r_est_y_ff >= DIM_BITS'(OUT_HEIGHT)) begin
         step_q_y_in = q_est_y_ff + DIM_BITS'(1);
         step_r_y_in = ROW_REM_BITS'(r_est_y_ff - DIM_BITS'(OUT_HEIGHT));
      end else begin
         step_q_y_in = q_est_y_ff;
         step_r_y_in = ROW_REM_BITS'(r_est_y_ff);
      end
   end

   always_ff @(posedge clock) begin
      side_ff     <= side_in;
      start_x_ff  <= start_x_in;
      start_y_ff  <= start_y_in;
      prod_x_ff   <= prod_x_in;
      prod_y_ff   <= prod_y_in;
      q_est_x_ff  <= q_est_x_in;
      q_est_y_ff  <= q_est_y_in;
      r_est_x_ff  <= r_est_x_in;
      r_est_y_ff  <= r_est_y_in;
      step_q_x_ff <= step_q_x_in;
      step_q_y_ff <= step_q_y_in;
      step_r_x_ff <= step_r_x_in;
      step_r_y_ff <= step_r_y_in;
   end

   assign busy      = (settle_ff != '0);
   assign req_stall = busy | queue_status.full;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      if (cfg_write) begin
         settle_in = SETTLE_BITS'(SETTLE_CYCLES);
      end else if (busy) begin
         settle_in = settle_ff - SETTLE_BITS'(1);
      end else begin
         settle_in = settle_ff;
      end
   end

   // a frame start clears the counters before the pixel is classified
   always_comb begin
      if (req_frame_start) begin
         cur_src_col    = '0;
         cur_src_row    = '0;
         cur_out_col    = '0;
         cur_out_row    = '0;
         cur_col_target = start_x_ff;
         cur_row_target = start_y_ff;
         cur_col_rem    = '0;
         cur_row_rem    = '0;
      end else begin
         cur_src_col    = src_col_ff;
         cur_src_row    = src_row_ff;
         cur_out_col    = out_col_ff;
         cur_out_row    = out_row_ff;
         cur_col_target = col_target_ff;
         cur_row_target = row_target_ff;
         cur_col_rem    = col_rem_ff;
         cur_row_rem    = row_rem_ff;
      end

      row_hit = (cur_out_row < OUT_ROW_BITS'(OUT_HEIGHT)) && (cur_src_row == cur_row_target);
      sel     = row_hit && (cur_out_col < OUT_COL_BITS'(OUT_WIDTH))
                && (cur_src_col == cur_col_target);
      last    = (cur_out_row == OUT_ROW_BITS'(OUT_HEIGHT - 1))
                && (cur_out_col == OUT_COL_BITS'(OUT_WIDTH - 1));
      row_end = ((DIM_BITS+1)'(cur_src_col) + (DIM_BITS+1)'(1))
                >= (DIM_BITS+1)'(cfg.frame_width);

      col_sum   = (COL_REM_BITS+1)'(cur_col_rem) + (COL_REM_BITS+1)'(step_r_x_ff);
      col_carry = col_sum >= (COL_REM_BITS+1)'(OUT_WIDTH);
      row_sum   = (ROW_REM_BITS+1)'(cur_row_rem) + (ROW_REM_BITS+1)'(step_r_y_ff);
      row_carry = row_sum >= (ROW_REM_BITS+1)'(OUT_HEIGHT);

      src_col_in    = cur_src_col;
      src_row_in    = cur_src_row;
      out_col_in    = cur_out_col;
      out_row_in    = cur_out_row;
      col_target_in = cur_col_target;
      row_target_in = cur_row_target;
      col_rem_in    = cur_col_rem;
      row_rem_in    = cur_row_rem;

      if (sel) begin
         out_col_in    = cur_out_col + OUT_COL_BITS'(1);
         col_target_in = cur_col_target + step_q_x_ff + DIM_BITS'(col_carry);
         col_rem_in    = col_carry ? COL_REM_BITS'(col_sum - (COL_REM_BITS+1)'(OUT_WIDTH))
                                   : COL_REM_BITS'(col_sum);
      end

      if (row_end) begin
         src_col_in = '0;
         if (row_hit) begin
            out_row_in    = cur_out_row + OUT_ROW_BITS'(1);
            row_target_in = cur_row_target + step_q_y_ff + DIM_BITS'(row_carry);
            row_rem_in    = row_carry ? ROW_REM_BITS'(row_sum - (ROW_REM_BITS+1)'(OUT_HEIGHT))
                                      : ROW_REM_BITS'(row_sum);
         end
         src_row_in    = cur_src_row + DIM_BITS'(1);
         out_col_in    = '0;
         col_target_in = start_x_ff;
         col_rem_in    = '0;
      end else begin
         src_col_in = cur_src_col + DIM_BITS'(1);
      end
   end

   assign push_valid            = accept & sel;
   assign push_entry.pixel      = req_pixel;
   assign push_entry.image_last = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff     <= SETTLE_BITS'(SETTLE_CYCLES);
         src_col_ff    <= '0;
         src_row_ff    <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         col_target_ff <= '0;
         row_target_ff <= '0;
         col_rem_ff    <= '0;
         row_rem_ff    <= '0;
      end else begin
         settle_ff <= settle_in;
         if (accept) begin
            src_col_ff    <= src_col_in;
            src_row_ff    <= src_row_in;
            out_col_ff    <= out_col_in;
            out_row_ff    <= out_row_in;
            col_target_ff <= col_target_in;
            row_target_ff <= row_target_in;
            col_rem_ff    <= col_rem_in;
            row_rem_ff    <= row_rem_in;
         end
      end
   end

endmodule

FILE: rtl/ccgd_queue.sv
module ccgd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  ccgd_pkg::entry_type        push_entry,
   input  logic                       pop,
   output ccgd_pkg::queue_status_type status,
   output ccgd_pkg::entry_type        head_entry
);
   import ccgd_pkg::*;

   entry_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_pop;

   assign status.full      = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign head_entry       = slot_ff[rd_ptr_ff];
   assign do_pop           = pop & status.not_empty;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_BITS'(push_valid) - QUEUE_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/ccgd_back.sv
module ccgd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  ccgd_pkg::queue_status_type    queue_status,
   input  ccgd_pkg::entry_type           head_entry,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ccgd_pkg::GRAY_BITS-1:0] rsp_gray,
   output logic                          rsp_image_last
);
   import ccgd_pkg::*;

   logic [4:0]  red, blue;
   logic [5:0]  green;
   logic [22:0] red_prod_ff, red_prod_in;
   logic [23:0] green_prod_ff, green_prod_in;
   logic [20:0] blue_prod_ff, blue_prod_in;
   logic        s1_last_ff;
   logic        s1_valid_ff;
   logic [24:0] luma_sum;
   logic [8:0]  luma_raw;
   logic [GRAY_BITS-1:0] gray_in;
   logic [GRAY_BITS-1:0] gray_ff;
   logic        last_ff;
   logic        valid_ff;
   logic        out_free;
   logic        s1_free;

   assign out_free = ~valid_ff | ~rsp_stall;
   assign s1_free  = ~s1_valid_ff | out_free;
   assign pop      = queue_status.not_empty & s1_free;

   always_comb begin
      red           = head_entry.pixel[15:11];
      green         = head_entry.pixel[10:5];
      blue          = head_entry.pixel[4:0];
      red_prod_in   = 23'(red) * 23'(W_RED);
      green_prod_in = 24'(green) * 24'(W_GREEN);
      blue_prod_in  = 21'(blue) * 21'(W_BLUE);
      luma_sum      = 25'(red_prod_ff) + 25'(green_prod_ff) + 25'(blue_prod_ff);
      luma_raw      = luma_sum[24:16];
      gray_in       = (luma_raw > 9'd255) ? 8'd255 : luma_raw[7:0];
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         red_prod_ff   <= red_prod_in;
         green_prod_ff <= green_prod_in;
         blue_prod_ff  <= blue_prod_in;
         s1_last_ff    <= head_entry.image_last;
      end
      if (out_free) begin
         gray_ff <= gray_in;
         last_ff <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= pop;
         end
         if (out_free) begin
            valid_ff <= s1_valid_ff;
         end
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_gray       = gray_ff;
   assign rsp_image_last = last_ff;

endmodule

FILE: rtl/center_crop_gray_downscaler.sv
// channel | direction | handshake                  | payload
// req     | in        | req_valid / req_stall      | req_pixel, req_frame_start
// rsp     | out       | rsp_valid / rsp_stall      | rsp_gray, rsp_image_last
// csr     | in        | csr_write                  | csr_index, csr_wdata
//
// one pixel taken per cycle while req_stall is low; a selected pixel passes the queue, product and output registers
// the 4-entry queue between selection and luma weighting absorbs output back-pressure
// req_stall is high after reset and after each csr write while crop steps settle
// req_stall is also high while the queue is full; reset is synchronous, active high
`include "assert_macros.svh"

module center_crop_gray_downscaler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [ccgd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ccgd_pkg::DIM_BITS-1:0]       csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ccgd_pkg::PIXEL_BITS-1:0]     req_pixel,
   input  logic                               req_frame_start,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ccgd_pkg::GRAY_BITS-1:0]      rsp_gray,
   output logic                               rsp_image_last
);
   import ccgd_pkg::*;

   cfg_type          cfg_ff;
   queue_status_type queue_status;
   entry_type        push_entry;
   entry_type        head_entry;
   logic             push_valid;
   logic             pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= FRAME_WIDTH_RESET;
         cfg_ff.frame_height <= FRAME_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  cfg_ff.frame_width  <= csr_wdata;
            REG_FRAME_HEIGHT: cfg_ff.frame_height <= csr_wdata;
         endcase
      end
   end

   ccgd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cfg_write       (csr_write),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .queue_status    (queue_status),
      .push_valid      (push_valid),
      .push_entry      (push_entry)
   );

   ccgd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .status     (queue_status),
      .head_entry (head_entry)
   );

   ccgd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_status   (queue_status),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_gray       (rsp_gray),
      .rsp_image_last (rsp_image_last)
   );

   `ASSERT_NEXT(a_csr_write_stalls, clock, reset, csr_write, req_stall)
   `ASSERT_IMPLIES(a_no_push_when_full, clock, reset, push_valid, !queue_status.full)
   `ASSERT_IMPLIES(a_pop_needs_entry, clock, reset, pop, queue_status.not_empty)

endmodule
